// ----- src/pll_divider_solver_core_assert.svh -----
// assertion macros used by the checker file
`ifndef PLL_DIVIDER_SOLVER_CORE_ASSERT_SVH
`define PLL_DIVIDER_SOLVER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Widths, codes, reset values and shared types of the PLL divider solver.
// ----------------------------------------------------------------------------
package pds_pkg;

  // field widths
  localparam int CLK_W      = 20;
  localparam int FLAG_W     = 5;
  localparam int GPOST_W    = 8;
  localparam int GREF_W     = 10;
  localparam int POST_W     = 8;
  localparam int REF_W      = 11;
  localparam int FB_W       = 12;
  localparam int FRAC_W     = 4;
  localparam int ACH_W      = 32;
  localparam int RF_W       = 20;
  localparam int VCO_W      = 22;
  localparam int TOL_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // shared divider widths
  localparam int NUM_W = 42;
  localparam int DEN_W = 22;

  // parameter defaults
  localparam int POST_MIN_DEF = 2;
  localparam int POST_MAX_DEF = 127;
  localparam int REF_MIN_DEF  = 2;
  localparam int REF_MAX_DEF  = 1023;
  localparam int FB_MIN_DEF   = 4;
  localparam int FB_MAX_DEF   = 2047;

  // register reset values
  localparam logic [RF_W-1:0]  RST_REF_FREQ = RF_W'(27000);
  localparam logic [VCO_W-1:0] RST_VCO_MIN  = VCO_W'(648000);
  localparam logic [VCO_W-1:0] RST_VCO_MAX  = VCO_W'(1200000);
  localparam logic [TOL_W-1:0] RST_TOL      = TOL_W'(1);

  // mode flag bit positions
  localparam int FLAG_GIVEN_POST = 0;
  localparam int FLAG_PREFER_MIN = 1;
  localparam int FLAG_LCD        = 2;
  localparam int FLAG_GIVEN_REF  = 3;
  localparam int FLAG_FRAC       = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_FREQ = 3'd0,
    CFG_VCO_MIN  = 3'd1,
    CFG_VCO_MAX  = 3'd2,
    CFG_LCD_MIN  = 3'd3,
    CFG_LCD_MAX  = 3'd4,
    CFG_TOL      = 3'd5
  } pds_cfg_idx_e;

  typedef struct packed {
    logic [RF_W-1:0]  ref_freq;
    logic [VCO_W-1:0] vco_min;
    logic [VCO_W-1:0] vco_max;
    logic [VCO_W-1:0] lcd_min;
    logic [VCO_W-1:0] lcd_max;
    logic [TOL_W-1:0] tol;
  } pds_cfg_t;

  typedef struct packed {
    logic [CLK_W-1:0]   tgt_clk;
    logic [FLAG_W-1:0]  flags;
    logic [GPOST_W-1:0] given_post;
    logic [GREF_W-1:0]  given_ref;
  } pds_req_t;

  typedef struct packed {
    logic [POST_W-1:0] post_div;
    logic [REF_W-1:0]  ref_div;
    logic [FB_W-1:0]   fb_div;
    logic [FRAC_W-1:0] fb_frac;
    logic [ACH_W-1:0]  achieved;
    logic              status;
  } pds_res_t;

  // x / 10 for x below 128, by reciprocal multiply
  function automatic logic [6:0] div10(input logic [6:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:11];
  endfunction

endpackage

// ----- src/pds_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_if
// Valid/ready channel interfaces for request, result and register writes.
// ----------------------------------------------------------------------------
interface pds_in_if;
  import pds_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLK_W-1:0]   pixel_clock_khz;
  logic [FLAG_W-1:0]  mode_flags;
  logic [GPOST_W-1:0] given_post_div;
  logic [GREF_W-1:0]  given_ref_div;
  modport source (output valid, pixel_clock_khz, mode_flags, given_post_div,
                  given_ref_div, input ready);
  modport sink (input valid, pixel_clock_khz, mode_flags, given_post_div,
                given_ref_div, output ready);
endinterface

interface pds_out_if;
  import pds_pkg::*;
  logic              valid;
  logic              ready;
  logic [POST_W-1:0] post_div;
  logic [REF_W-1:0]  ref_div;
  logic [FB_W-1:0]   fb_div;
  logic [FRAC_W-1:0] fb_frac;
  logic [ACH_W-1:0]  achieved_clock_khz;
  logic              status;
  modport source (output valid, post_div, ref_div, fb_div, fb_frac,
                  achieved_clock_khz, status, input ready);
  modport sink (input valid, post_div, ref_div, fb_div, fb_frac,
                achieved_clock_khz, status, output ready);
endinterface

interface pds_cfg_if;
  import pds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/pds_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_div
// Restoring divider, one quotient bit per cycle, shared by every division.
// ----------------------------------------------------------------------------
module pds_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pds_pkg::NUM_W-1:0] num_i,
  input  logic [pds_pkg::DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [pds_pkg::NUM_W-1:0] quo_o,
  output logic [pds_pkg::DEN_W-1:0] rem_o
);
  import pds_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic             ge;

  // one shift-subtract step
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/pds_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer that drives the shared divider through post, feedback, search
// and achieved-clock steps.
// ----------------------------------------------------------------------------
module pds_ctrl #(
  parameter int POST_MIN = pds_pkg::POST_MIN_DEF,
  parameter int POST_MAX = pds_pkg::POST_MAX_DEF,
  parameter int REF_MIN  = pds_pkg::REF_MIN_DEF,
  parameter int REF_MAX  = pds_pkg::REF_MAX_DEF,
  parameter int FB_MIN   = pds_pkg::FB_MIN_DEF,
  parameter int FB_MAX   = pds_pkg::FB_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pds_pkg::pds_req_t req_i,
  input  pds_pkg::pds_cfg_t cfg_i,
  output logic              idle_o,
  output logic              done_o,
  input  logic              ack_i,
  output pds_pkg::pds_res_t res_o
);
  import pds_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DGO   = 12'b0000_0000_0010,
    S_DWAIT = 12'b0000_0000_0100,
    S_SEL   = 12'b0000_0000_1000,
    S_MUL1  = 12'b0000_0001_0000,
    S_MUL2  = 12'b0000_0010_0000,
    S_MUL3  = 12'b0000_0100_0000,
    S_MUL4  = 12'b0000_1000_0000,
    S_FRMUL = 12'b0001_0000_0000,
    S_ACH1  = 12'b0010_0000_0000,
    S_ACH2  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } pds_state_e;

  typedef enum logic [2:0] {
    OP_POST = 3'd0,
    OP_FB   = 3'd1,
    OP_FRAC = 3'd2,
    OP_RAT1 = 3'd3,
    OP_RAT2 = 3'd4,
    OP_ACH  = 3'd5
  } pds_op_e;

  pds_state_e state_q, state_d;
  pds_op_e    op_q, op_d;

  logic [CLK_W-1:0]  clk_q, clk_d;
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [GREF_W-1:0] gref_q, gref_d;
  logic [POST_W-1:0] post_q, post_d;
  logic [REF_W-1:0]  ref_q, ref_d;
  logic [FB_W-1:0]   fb_q, fb_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [ACH_W-1:0]  ach_q, ach_d;
  logic              err_q, err_d;
  logic [18:0]       pr_q, pr_d;
  logic [15:0]       w_q, w_d;
  logic [RF_W-1:0]   rem_q, rem_d;
  logic [31:0]       ratio_q, ratio_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;

  logic             div_start, div_done;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;

  logic [VCO_W-1:0] vco_sel;
  logic [22:0]      qp;
  logic [FB_W-1:0]  fb_cl;
  logic [6:0]       f_raw;
  logic [FRAC_W:0]  f_rnd;
  logic [10:0]      hi_lim, lo_lim;

  pds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  // tolerance window
  assign hi_lim = 11'd1000 + 11'(cfg_i.tol);
  assign lo_lim = (cfg_i.tol >= TOL_W'(1000)) ? 11'd0 : 11'd1000 - 11'(cfg_i.tol);

  // vco limit picked by mode
  always_comb begin
    if (flags_q[FLAG_PREFER_MIN]) vco_sel = flags_q[FLAG_LCD] ? cfg_i.lcd_min : cfg_i.vco_min;
    else                          vco_sel = flags_q[FLAG_LCD] ? cfg_i.lcd_max : cfg_i.vco_max;
  end

  // post divider rounding and clamp
  always_comb begin
    qp = {1'b0, quo[VCO_W-1:0]};
    if (flags_q[FLAG_PREFER_MIN]) begin
      if (rem != '0) qp = qp + 23'd1;
    end else if (rem == '0 && qp != '0) begin
      qp = qp - 23'd1;
    end
    if (qp > 23'(POST_MAX))      qp = 23'(POST_MAX);
    else if (qp < 23'(POST_MIN)) qp = 23'(POST_MIN);
  end

  // feedback clamp
  always_comb begin
    if (quo > NUM_W'(FB_MAX))      fb_cl = FB_W'(FB_MAX);
    else if (quo < NUM_W'(FB_MIN)) fb_cl = FB_W'(FB_MIN);
    else                           fb_cl = quo[FB_W-1:0];
  end

  // tenths rounding
  always_comb begin
    f_raw = quo[6:0];
    if (f_raw >= 7'd5) f_rnd = 5'(div10(f_raw - 7'd5)) + 5'd1;
    else               f_rnd = 5'(f_raw);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    clk_d     = clk_q;
    flags_d   = flags_q;
    gref_d    = gref_q;
    post_d    = post_q;
    ref_d     = ref_q;
    fb_d      = fb_q;
    frac_d    = frac_q;
    ach_d     = ach_q;
    err_d     = err_q;
    pr_d      = pr_q;
    w_d       = w_q;
    rem_d     = rem_q;
    ratio_d   = ratio_q;
    num_d     = num_q;
    den_d     = den_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          clk_d   = req_i.tgt_clk;
          flags_d = req_i.flags;
          gref_d  = req_i.given_ref;
          post_d  = req_i.given_post;
          fb_d    = '0;
          frac_d  = '0;
          ach_d   = '0;
          err_d   = 1'b0;
          if (req_i.tgt_clk == '0 || cfg_i.ref_freq == '0) begin
            err_d   = 1'b1;
            state_d = S_DONE;
          end else if (req_i.flags[FLAG_GIVEN_POST]) begin
            state_d = S_SEL;
          end else begin
            state_d = S_MUL1;
            op_d    = OP_POST;
          end
        end
      end
      S_MUL1: begin
        // post divider division, or post times ref for the feedback
        if (op_q == OP_POST) begin
          num_d   = NUM_W'(vco_sel);
          den_d   = DEN_W'(clk_q);
          state_d = S_DGO;
        end else begin
          pr_d    = 19'(post_q) * 19'(ref_q);
          state_d = S_MUL2;
        end
      end
      S_SEL: begin
        ref_d = flags_q[FLAG_GIVEN_REF] ? REF_W'(gref_q) : REF_W'(REF_MIN);
        if (post_q == '0 || (flags_q[FLAG_GIVEN_REF] && gref_q == '0)) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else if (!flags_q[FLAG_FRAC] && flags_q[FLAG_GIVEN_REF] &&
                     REF_W'(gref_q) > REF_W'(REF_MAX)) begin
          state_d = S_ACH1;
        end else begin
          op_d    = OP_FB;
          state_d = S_MUL1;
        end
      end
      S_MUL2: begin
        num_d   = NUM_W'(pr_q) * NUM_W'(clk_q);
        den_d   = DEN_W'(cfg_i.ref_freq);
        op_d    = OP_FB;
        state_d = S_DGO;
      end
      S_FRMUL: begin
        num_d   = NUM_W'(rem_q) * NUM_W'(100);
        den_d   = DEN_W'(cfg_i.ref_freq);
        op_d    = OP_FRAC;
        state_d = S_DGO;
      end
      S_MUL3: begin
        num_d   = NUM_W'(cfg_i.ref_freq) * NUM_W'(fb_q);
        den_d   = DEN_W'(pr_q);
        op_d    = OP_RAT1;
        state_d = S_DGO;
      end
      S_MUL4: begin
        num_d   = NUM_W'(ratio_q) * NUM_W'(1000);
        den_d   = DEN_W'(clk_q);
        op_d    = OP_RAT2;
        state_d = S_DGO;
      end
      S_ACH1: begin
        w_d     = 16'(fb_q) * 16'd10 + 16'(frac_q);
        pr_d    = 19'(post_q) * 19'(ref_q);
        state_d = S_ACH2;
      end
      S_ACH2: begin
        num_d   = NUM_W'(cfg_i.ref_freq) * NUM_W'(w_q);
        den_d   = DEN_W'(pr_q) * DEN_W'(10);
        op_d    = OP_ACH;
        state_d = S_DGO;
      end
      S_DGO: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          case (op_q)
            OP_POST: begin
              post_d  = POST_W'(qp);
              state_d = S_SEL;
            end
            OP_FB: begin
              rem_d = rem[RF_W-1:0];
              if (flags_q[FLAG_FRAC]) begin
                fb_d    = fb_cl;
                state_d = S_FRMUL;
              end else begin
                fb_d    = (rem[RF_W-1:0] >= (cfg_i.ref_freq >> 1)) ? fb_cl + FB_W'(1) : fb_cl;
                frac_d  = '0;
                state_d = S_MUL3;
              end
            end
            OP_FRAC: begin
              if (f_rnd >= 5'd10) begin
                fb_d   = fb_q + FB_W'(1);
                frac_d = '0;
              end else begin
                frac_d = f_rnd[FRAC_W-1:0];
              end
              state_d = S_ACH1;
            end
            OP_RAT1: begin
              ratio_d = quo[31:0];
              state_d = S_MUL4;
            end
            OP_RAT2: begin
              if (quo <= NUM_W'(hi_lim) && quo >= NUM_W'(lo_lim)) begin
                state_d = S_ACH1;
              end else begin
                ref_d = ref_q + REF_W'(1);
                if (ref_q + REF_W'(1) > REF_W'(REF_MAX)) state_d = S_ACH1;
                else                                    state_d = S_MUL1;
              end
            end
            OP_ACH: begin
              ach_d   = quo[ACH_W-1:0];
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (ack_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_POST;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    clk_q   <= clk_d;
    flags_q <= flags_d;
    gref_q  <= gref_d;
    post_q  <= post_d;
    ref_q   <= ref_d;
    fb_q    <= fb_d;
    frac_q  <= frac_d;
    ach_q   <= ach_d;
    err_q   <= err_d;
    pr_q    <= pr_d;
    w_q     <= w_d;
    rem_q   <= rem_d;
    ratio_q <= ratio_d;
    num_q   <= num_d;
    den_q   <= den_d;
  end

  // result, zeroed on error
  assign idle_o = state_q == S_IDLE;
  assign done_o = state_q == S_DONE;
  always_comb begin
    res_o.post_div = err_q ? '0 : post_q;
    res_o.ref_div  = err_q ? '0 : ref_q;
    res_o.fb_div   = err_q ? '0 : fb_q;
    res_o.fb_frac  = err_q ? '0 : frac_q;
    res_o.achieved = err_q ? '0 : ach_q;
    res_o.status   = err_q;
  end

endmodule

// ----- src/pll_divider_solver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_divider_solver_core
// Display PLL divider solver: post, reference and feedback dividers.
// ----------------------------------------------------------------------------
// Usage
// - in_i takes one request transaction (pixel clock, mode flags, given
//   dividers); in_i.ready is high only while the solver is idle.
// - out_o carries one result transaction per request, held in an output
//   register until out_o.ready; a new request is taken meanwhile.
// - cfg_i writes the six limit registers at any time it is valid; it is
//   always ready. It is to be written only while no request is in
//   flight; the user is bound to this and the block does not enforce it.
// - Every division runs on one shared divider in 42 steps. The integer
//   search tries reference dividers upward from its start, at most up to
//   REF_MAX. A zero clock or zero given post divider gives its result
//   without a division, a zero given reference divider right after the
//   post divider.
// - Reset loads the register defaults and empties the output register.
// - If out_o is stalled, a finished result waits inside the sequencer and
//   the next request is held off until the output register frees.
// ----------------------------------------------------------------------------
module pll_divider_solver_core #(
  parameter int POST_MIN = pds_pkg::POST_MIN_DEF,
  parameter int POST_MAX = pds_pkg::POST_MAX_DEF,
  parameter int REF_MIN  = pds_pkg::REF_MIN_DEF,
  parameter int REF_MAX  = pds_pkg::REF_MAX_DEF,
  parameter int FB_MIN   = pds_pkg::FB_MIN_DEF,
  parameter int FB_MAX   = pds_pkg::FB_MAX_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  pds_in_if.sink    in_i,
  pds_out_if.source out_o,
  pds_cfg_if.sink   cfg_i
);
  import pds_pkg::*;

  pds_cfg_t cfg_q, cfg_d;
  pds_req_t req;
  pds_res_t res, res_q;
  logic     idle, done, ack, out_valid_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (pds_cfg_idx_e'(cfg_i.index))
        CFG_REF_FREQ: cfg_d.ref_freq = cfg_i.data[RF_W-1:0];
        CFG_VCO_MIN:  cfg_d.vco_min  = cfg_i.data[VCO_W-1:0];
        CFG_VCO_MAX:  cfg_d.vco_max  = cfg_i.data[VCO_W-1:0];
        CFG_LCD_MIN:  cfg_d.lcd_min  = cfg_i.data[VCO_W-1:0];
        CFG_LCD_MAX:  cfg_d.lcd_max  = cfg_i.data[VCO_W-1:0];
        CFG_TOL:      cfg_d.tol      = cfg_i.data[TOL_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_freq <= RST_REF_FREQ;
      cfg_q.vco_min  <= RST_VCO_MIN;
      cfg_q.vco_max  <= RST_VCO_MAX;
      cfg_q.lcd_min  <= RST_VCO_MIN;
      cfg_q.lcd_max  <= RST_VCO_MAX;
      cfg_q.tol      <= RST_TOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // request intake
  assign in_i.ready      = idle;
  assign req.tgt_clk     = in_i.pixel_clock_khz;
  assign req.flags       = in_i.mode_flags;
  assign req.given_post  = in_i.given_post_div;
  assign req.given_ref   = in_i.given_ref_div;

  pds_ctrl #(
    .POST_MIN (POST_MIN),
    .POST_MAX (POST_MAX),
    .REF_MIN  (REF_MIN),
    .REF_MAX  (REF_MAX),
    .FB_MIN   (FB_MIN),
    .FB_MAX   (FB_MAX)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_i.valid & idle),
    .req_i   (req),
    .cfg_i   (cfg_q),
    .idle_o  (idle),
    .done_o  (done),
    .ack_i   (ack),
    .res_o   (res)
  );

  // output register
  assign ack = done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) res_q <= res;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.post_div           = res_q.post_div;
  assign out_o.ref_div            = res_q.ref_div;
  assign out_o.fb_div             = res_q.fb_div;
  assign out_o.fb_frac            = res_q.fb_frac;
  assign out_o.achieved_clock_khz = res_q.achieved;
  assign out_o.status             = res_q.status;

endmodule

// ----- src/pds_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the PLL divider solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "pll_divider_solver_core_assert.svh"

module pds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [pds_pkg::POST_W-1:0] post_div_i,
  input logic [pds_pkg::FB_W-1:0]   fb_div_i,
  input logic [pds_pkg::FRAC_W-1:0] fb_frac_i,
  input logic                       status_i
);
  import pds_pkg::*;

  // stalled result holds
  `PDS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(fb_div_i), "stalled result dropped or changed")

  // solver is busy right after taking a request
  `PDS_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_i, !in_ready_i, "request taken while solving")

  // error results carry zero dividers
  `PDS_ASSERT_NOW(a_err_zero, out_valid_i && status_i, post_div_i == '0 && fb_div_i == '0, "error result not zeroed")

  // fraction stays in tenths
  `PDS_ASSERT_NOW(a_frac_range, out_valid_i, fb_frac_i <= FRAC_W'(9), "fraction above nine tenths")

endmodule

bind pll_divider_solver_core pds_checker u_pds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .post_div_i  (out_o.post_div),
  .fb_div_i    (out_o.fb_div),
  .fb_frac_i   (out_o.fb_frac),
  .status_i    (out_o.status)
);

// ----- test/pll_divider_solver_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_divider_solver_core_test
// Self-checking bench for the PLL divider solver: directed corner requests
// and random requests across several register settings, each result checked
// against a behavioral divider calculation with random idling on both sides.
// ----------------------------------------------------------------------------
module pll_divider_solver_core_test;
  import pds_pkg::*;

  localparam int POST_LO = 2;
  localparam int POST_HI = 127;
  localparam int REF_LO  = 2;
  localparam int REF_HI  = 1023;
  localparam int FB_LO   = 4;
  localparam int FB_HI   = 2047;

  logic clk_i;
  logic rst_ni;

  pds_in_if  req_if ();
  pds_out_if res_if ();
  pds_cfg_if cfg_if ();

  pll_divider_solver_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // register shadow
  longint unsigned rf_khz, vmin_khz, vmax_khz, lmin_khz, lmax_khz, tol_pm;

  pds_res_t expected_divs[$];
  int       fail_cnt;
  bit       no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit, covers a full reference search on every request
  initial begin
    #2_000_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned clamp_feedback(longint unsigned v);
    if (v > FB_HI) return 64'(FB_HI);
    if (v < FB_LO) return 64'(FB_LO);
    return v;
  endfunction

  // divider calculation for one request
  function automatic pds_res_t solve_dividers(pds_req_t rq);
    longint unsigned clk, post, rdv, fb, frac, t, ratio, hi_lim, lo_lim, vco, q, r, ach;
    bit pm, lcd;
    pds_res_t res;
    res = '0;
    clk = 64'(rq.tgt_clk);
    fb = 0;
    frac = 0;
    if (clk == 0 || rf_khz == 0) begin
      res.status = 1'b1;
      return res;
    end
    pm  = rq.flags[FLAG_PREFER_MIN];
    lcd = rq.flags[FLAG_LCD];
    if (rq.flags[FLAG_GIVEN_POST]) begin
      post = 64'(rq.given_post);
    end else begin
      if (pm) vco = lcd ? lmin_khz : vmin_khz;
      else vco = lcd ? lmax_khz : vmax_khz;
      q = vco / clk;
      r = vco % clk;
      if (pm) begin
        if (r != 0) q++;
      end else if (r == 0 && q > 0) begin
        q--;
      end
      if (q > POST_HI) q = 64'(POST_HI);
      else if (q < POST_LO) q = 64'(POST_LO);
      post = q;
    end
    rdv = rq.flags[FLAG_GIVEN_REF] ? 64'(rq.given_ref) : 64'(REF_LO);
    if (post == 0 || rdv == 0) begin
      res.status = 1'b1;
      return res;
    end
    hi_lim = 1000 + tol_pm;
    lo_lim = (tol_pm >= 1000) ? 0 : 1000 - tol_pm;
    if (rq.flags[FLAG_FRAC]) begin
      t = post * rdv * clk;
      fb = clamp_feedback(t / rf_khz);
      frac = (100 * (t % rf_khz)) / rf_khz;
      if (frac >= 5) frac = (frac - 5) / 10 + 1;
      if (frac >= 10) begin
        fb++;
        frac = 0;
      end
    end else begin
      // upward search over reference dividers
      while (rdv <= REF_HI) begin
        t = post * rdv * clk;
        fb = clamp_feedback(t / rf_khz);
        if (t % rf_khz >= rf_khz / 2) fb++;
        frac = 0;
        ratio = (rf_khz * fb) / (post * rdv);
        ratio = (ratio * 1000) / clk;
        if (ratio <= hi_lim && ratio >= lo_lim) break;
        rdv++;
      end
    end
    ach = (rf_khz * fb * 10 + rf_khz * frac) / (rdv * post * 10);
    res.post_div = post[POST_W-1:0];
    res.ref_div  = rdv[REF_W-1:0];
    res.fb_div   = fb[FB_W-1:0];
    res.fb_frac  = frac[FRAC_W-1:0];
    res.achieved = ach[ACH_W-1:0];
    res.status   = 1'b0;
    return res;
  endfunction

  // send one request transaction; valid stays high for a back-to-back follower
  task automatic send_request(input logic [CLK_W-1:0] clk, input logic [FLAG_W-1:0] flags,
                              input logic [GPOST_W-1:0] gpost,
                              input logic [GREF_W-1:0] gref);
    int gap;
    pds_req_t rq;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq = '{tgt_clk: clk, flags: flags, given_post: gpost, given_ref: gref};
    req_if.pixel_clock_khz <= clk;
    req_if.mode_flags      <= flags;
    req_if.given_post_div  <= gpost;
    req_if.given_ref_div   <= gref;
    req_if.valid           <= 1'b1;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    expected_divs.push_back(solve_dividers(rq));
  endtask

  // drain all results, then let the solver settle before touching registers
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_divs.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input pds_cfg_idx_e idx, input longint unsigned value);
    cfg_if.index <= idx;
    cfg_if.data  <= value[CFG_DATA_W-1:0];
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_REF_FREQ: rf_khz   = value & 64'hFFFFF;
      CFG_VCO_MIN:  vmin_khz = value & 64'h3FFFFF;
      CFG_VCO_MAX:  vmax_khz = value & 64'h3FFFFF;
      CFG_LCD_MIN:  lmin_khz = value & 64'h3FFFFF;
      CFG_LCD_MAX:  lmax_khz = value & 64'h3FFFFF;
      default:      tol_pm   = value & 64'h3FF;
    endcase
  endtask

  task automatic write_all(input longint unsigned rf, vmin, vmax, lmin, lmax, tol);
    write_reg(CFG_REF_FREQ, rf);
    write_reg(CFG_VCO_MIN, vmin);
    write_reg(CFG_VCO_MAX, vmax);
    write_reg(CFG_LCD_MIN, lmin);
    write_reg(CFG_LCD_MAX, lmax);
    write_reg(CFG_TOL, tol);
  endtask

  // random request; integer mode is kept where the search converges quickly
  task automatic send_random(input bit frac_only);
    logic [FLAG_W-1:0]  flags;
    logic [CLK_W-1:0]   clk;
    logic [GPOST_W-1:0] gpost;
    logic [GREF_W-1:0]  gref;
    flags = FLAG_W'($urandom);
    gpost = GPOST_W'($urandom);
    gref  = GREF_W'($urandom);
    if (frac_only || $urandom_range(0, 2) == 0) begin
      flags[FLAG_FRAC] = 1'b1;
      clk = ($urandom_range(0, 40) == 0) ? '0 : CLK_W'($urandom);
    end else if (flags[FLAG_GIVEN_POST]) begin
      clk   = CLK_W'($urandom_range(20000, 100000));
      gpost = GPOST_W'($urandom_range(1, 20));
      gref  = GREF_W'($urandom_range(2, 20));
    end else begin
      clk  = CLK_W'($urandom_range(20000, 1048575));
      gref = GREF_W'($urandom_range(2, 20));
    end
    send_request(clk, flags, gpost, gref);
  endtask

  // zero clock and zero given dividers
  task automatic test_errors();
    send_request('0, 5'b00000, 8'd0, 10'd0);
    send_request(20'd100000, 5'b00001, 8'd0, 10'd5);
    send_request(20'd100000, 5'b01000, 8'd3, 10'd0);
    send_request(20'd100000, 5'b11001, 8'd0, 10'd0);
  endtask

  // post divider rounding and clamping
  task automatic test_post_rounding();
    send_request(20'd300000, 5'b00000, 8'd0, 10'd0);   // exact, rounded down
    send_request(20'd600000, 5'b00000, 8'd0, 10'd0);   // exact, clamped to minimum
    send_request(20'd100000, 5'b00010, 8'd0, 10'd0);   // rounded up
    send_request(20'd1048575, 5'b00110, 8'd0, 10'd0);  // lcd, clamp low
    send_request(20'd1, 5'b10100, 8'd0, 10'd0);        // clamp high
    send_request(20'd74250, 5'b00100, 8'd0, 10'd0);
  endtask

  // fractional rounding and carry into the integer part
  task automatic test_fractional();
    send_request(20'd53000, 5'b11001, 8'd1, 10'd1);    // ten tenths carry
    send_request(20'd27000, 5'b11001, 8'd1, 10'd1);    // no remainder
    send_request(20'd148500, 5'b10000, 8'd0, 10'd0);
    send_request(20'hFFFFF, 5'b11001, 8'hFF, 10'h3FF); // widest product
  endtask

  // reference search from a given start, including a failing search
  task automatic test_search();
    send_request(20'd65000, 5'b01000, 8'd0, 10'd2);
    send_request(20'd25175, 5'b00011, 8'd4, 10'd0);
    send_request(20'd1000000, 5'b01001, 8'd200, 10'd1000); // fails past maximum
    send_request(20'd162000, 5'b01000, 8'd0, 10'd1023);
    drain_results();
  endtask

  // random phases over several register settings
  task automatic test_random_phases();
    write_all(14318, 400000, 1600000, 500000, 1000000, 5);
    no_idle = 1'b1;
    repeat (60) send_random(1'b0);
    no_idle = 1'b0;
    repeat (40) send_random(1'b0);
    drain_results();
    write_all(100000, 648000, 1200000, 800000, 2000000, 999);
    repeat (100) send_random(1'b0);
    drain_results();
    write_all(27000, 648000, 1200000, 648000, 1200000, 1);
    repeat (50) send_random(1'b0);
    drain_results();
  endtask

  // register extremes, fractional requests only
  task automatic test_config_extremes();
    write_all(655350, 0, 4194303, 4194303, 0, 0);
    send_request(20'd655978, 5'b11001, 8'd2, 10'd1023); // feedback rounds past maximum
    repeat (25) send_random(1'b1);
    drain_results();
    write_all(1, 4194303, 0, 0, 4194303, 999);
    repeat (25) send_random(1'b1);
    drain_results();
  endtask

  // result ready with random stalls
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  // result checking
  always @(posedge clk_i) begin
    pds_res_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_divs.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_cnt++;
      end else begin
        exp_res = expected_divs.pop_front();
        if (res_if.post_div !== exp_res.post_div) begin
          $error("post_div expected %0d actual %0d", exp_res.post_div, res_if.post_div);
          fail_cnt++;
        end
        if (res_if.ref_div !== exp_res.ref_div) begin
          $error("ref_div expected %0d actual %0d", exp_res.ref_div, res_if.ref_div);
          fail_cnt++;
        end
        if (res_if.fb_div !== exp_res.fb_div) begin
          $error("fb_div expected %0d actual %0d", exp_res.fb_div, res_if.fb_div);
          fail_cnt++;
        end
        if (res_if.fb_frac !== exp_res.fb_frac) begin
          $error("fb_frac expected %0d actual %0d", exp_res.fb_frac, res_if.fb_frac);
          fail_cnt++;
        end
        if (res_if.achieved_clock_khz !== exp_res.achieved) begin
          $error("achieved_clock_khz expected %0d actual %0d", exp_res.achieved,
                 res_if.achieved_clock_khz);
          fail_cnt++;
        end
        if (res_if.status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, res_if.status);
          fail_cnt++;
        end
      end
    end
  end

  // main sequence
  initial begin
    fail_cnt = 0;
    no_idle  = 1'b0;
    rf_khz = 27000;
    vmin_khz = 648000;
    vmax_khz = 1200000;
    lmin_khz = 648000;
    lmax_khz = 1200000;
    tol_pm = 1;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.pixel_clock_khz <= '0;
    req_if.mode_flags <= '0;
    req_if.given_post_div <= '0;
    req_if.given_ref_div <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_REF_FREQ;
    cfg_if.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_errors();
    test_post_rounding();
    test_fractional();
    test_search();
    test_random_phases();
    test_config_extremes();

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/pds_pkg.sv
src/pds_if.sv
src/pds_div.sv
src/pds_ctrl.sv
src/pll_divider_solver_core.sv
src/pds_checker.sv
test/pll_divider_solver_core_test.sv
